@@ design/rgb_hsv_color_convert_assert.svh @@
// Assertion macros for the color converter.
`ifndef RGB_HSV_COLOR_CONVERT_ASSERT_SVH
`define RGB_HSV_COLOR_CONVERT_ASSERT_SVH

// Clocked assertion, disabled during reset.
`define RHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rhc_pkg.sv @@
package rhc_pkg;

  localparam logic REQ_RGB2HSV = 1'b0;
  localparam logic REQ_HSV2RGB = 1'b1;

  localparam int CH_W      = 8;
  localparam int HUE_W     = 11;
  localparam int NUM_W     = 26;
  localparam int DEN_W     = 17;
  localparam int REM_W     = 27;
  localparam int QUO_W     = 10;
  localparam int STEP_BITS = 2;
  localparam int DIV_STEPS = QUO_W / STEP_BITS;
  localparam int LANES     = 2;

  localparam logic [HUE_W-1:0] HUE_TURN   = 11'd1536;
  localparam logic [HUE_W-1:0] OFS_RED    = 11'd1280;
  localparam logic [HUE_W-1:0] OFS_GREEN  = 11'd256;
  localparam logic [HUE_W-1:0] OFS_BLUE   = 11'd768;
  localparam logic [15:0]      FRAC_DEN   = 16'd65280;
  localparam logic [DEN_W-1:0] DEN_P      = 17'd510;
  localparam logic [DEN_W-1:0] DEN_QT     = 17'd130560;

  typedef enum logic [1:0] {
    BASE_RED,
    BASE_GREEN,
    BASE_BLUE
  } hue_base_t;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic [REM_W-1:0] rem_t;
  typedef logic [QUO_W-1:0] quo_t;

  typedef struct packed {
    logic            mode;
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] delta;
    logic [8:0]      dplus;
    hue_base_t       base;
    logic [CH_W-1:0] val;
    logic [CH_W-1:0] sat;
    logic [2:0]      sext;
    logic [15:0]     sf;
    logic [15:0]     st;
  } front_t;

  typedef struct packed {
    logic            mode;
    logic [CH_W-1:0] alpha;
    logic            gray;
    hue_base_t       base;
    logic [CH_W-1:0] val;
    logic [2:0]      sext;
  } side_t;

endpackage

@@ design/rgb_hsv_color_convert.sv @@
// RGB <-> HSV pixel converter.
// Input channel: in_valid/in_ready with req_type, red, green, blue, hue,
// saturation, value and alpha. req_type 0 gives hue/saturation/value,
// req_type 1 gives red/green/blue; unused result fields are zero and
// alpha passes through.
// Output channel: out_valid/out_ready with the out_* fields.
// One word is taken every cycle while in_ready is high. The 10-bit
// quotients come from two restoring divider lanes, 2 quotient bits
// per stage over five stages, which set the depth; the third mode 1
// channel divides by a constant with a shift-and-add step at the
// output stage.
// Reset clears all stage valid bits; no word is in flight afterwards.
// When the receiver stalls the whole pipeline holds, and in_ready drops
// only while a result waits at the output and out_ready is low, so no
// word is lost or repeated.
module rgb_hsv_color_convert (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [7:0]                 red,
  input  logic [7:0]                 green,
  input  logic [7:0]                 blue,
  input  logic [10:0]                hue,
  input  logic [7:0]                 saturation,
  input  logic [7:0]                 value,
  input  logic [7:0]                 alpha,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue,
  output logic [10:0]                out_hue,
  output logic [7:0]                 out_saturation,
  output logic [7:0]                 out_value,
  output logic [7:0]                 out_alpha
);
  import rhc_pkg::*;

  logic adv;
  logic vld_front;
  logic vld_div [DIV_STEPS+1];

  front_t front_next;
  front_t front;

  side_t side [DIV_STEPS+1];
  rem_t  rem  [DIV_STEPS+1][LANES];
  den_t  den  [DIV_STEPS+1][LANES];
  quo_t  quo  [DIV_STEPS+1][LANES];
  num_t  tnum [DIV_STEPS+1];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Front stage: channel extremes, hue split, saturation products.
  logic [CH_W-1:0]  mx, mn;
  logic [HUE_W-1:0] h_eff;
  logic [9:0]       dsum;
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    h_eff = (hue >= HUE_TURN) ? '0 : hue;
    front_next.mode  = req_type;
    front_next.alpha = alpha;
    front_next.mx    = mx;
    front_next.delta = mx - mn;
    if (red == mx) begin
      front_next.base = BASE_RED;
      dsum = ({2'b0, green} + {2'b0, mx}) - ({2'b0, blue} + {2'b0, mn});
    end else if (green == mx) begin
      front_next.base = BASE_GREEN;
      dsum = ({2'b0, blue} + {2'b0, mx}) - ({2'b0, red} + {2'b0, mn});
    end else begin
      front_next.base = BASE_BLUE;
      dsum = ({2'b0, red} + {2'b0, mx}) - ({2'b0, green} + {2'b0, mn});
    end
    front_next.dplus = dsum[8:0];
    front_next.val   = value;
    front_next.sat   = saturation;
    front_next.sext  = h_eff[10:8];
    front_next.sf    = 16'(saturation) * 16'(h_eff[7:0]);
    front_next.st    = {saturation, 8'd0} - front_next.sf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_front <= 1'b0;
    end else if (adv) begin
      vld_front <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front <= front_next;
    end
  end

  // Numerator and denominator setup for the divider lanes.
  num_t            n_next [LANES];
  den_t            d_next [LANES];
  num_t            tnum_next;
  side_t           side_next;
  logic [CH_W-1:0] s_inv;
  always_comb begin
    s_inv = 8'd255 - front.sat;
    if (front.mode == REQ_RGB2HSV) begin
      n_next[0] = NUM_W'(front.delta) * NUM_W'(510) + NUM_W'(front.mx);
      d_next[0] = DEN_W'({front.mx, 1'b0});
      n_next[1] = NUM_W'({front.dplus, 9'd0}) + NUM_W'(front.delta);
      d_next[1] = DEN_W'({front.delta, 1'b0});
      tnum_next = '0;
    end else begin
      n_next[0] = NUM_W'({16'(front.val) * 16'(s_inv), 1'b0}) + NUM_W'(255);
      d_next[0] = DEN_P;
      n_next[1] = NUM_W'({24'(front.val) * 24'(FRAC_DEN - front.sf), 1'b0})
                + NUM_W'(FRAC_DEN);
      d_next[1] = DEN_QT;
      tnum_next = NUM_W'({24'(front.val) * 24'(FRAC_DEN - front.st), 1'b0})
                + NUM_W'(FRAC_DEN);
    end
    side_next.mode  = front.mode;
    side_next.alpha = front.alpha;
    side_next.gray  = (front.delta == '0);
    side_next.base  = front.base;
    side_next.val   = (front.mode == REQ_RGB2HSV) ? front.mx : front.val;
    side_next.sext  = front.sext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_div[0] <= 1'b0;
    end else if (adv) begin
      vld_div[0] <= vld_front;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_next;
      tnum[0] <= tnum_next;
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= REM_W'(n_next[l]);
        den[0][l] <= d_next[l];
        quo[0][l] <= '0;
      end
    end
  end

  // Restoring division, two quotient bits per stage.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    rem_t r_next [LANES];
    quo_t q_next [LANES];
    always_comb begin
      rem_t sh;
      for (int l = 0; l < LANES; l++) begin
        r_next[l] = rem[j][l];
        q_next[l] = quo[j][l];
        for (int b = 0; b < STEP_BITS; b++) begin
          sh = REM_W'(den[j][l]) << (QUO_W - 1 - STEP_BITS * j - b);
          if (r_next[l] >= sh) begin
            r_next[l] = r_next[l] - sh;
            q_next[l] = q_next[l] | (QUO_W'(1) << (QUO_W - 1 - STEP_BITS * j - b));
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_div[j+1] <= 1'b0;
      end else if (adv) begin
        vld_div[j+1] <= vld_div[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[j+1] <= side[j];
        tnum[j+1] <= tnum[j];
        for (int l = 0; l < LANES; l++) begin
          rem[j+1][l] <= r_next[l];
          den[j+1][l] <= den[j][l];
          quo[j+1][l] <= q_next[l];
        end
      end
    end
  end

  // Final assembly: hue offset and wrap, sextant routing.
  side_t            fin;
  logic [HUE_W-1:0] hsum;
  logic [HUE_W-1:0] ofs;
  logic [16:0]      tm, tsum;
  logic [CH_W-1:0]  cp, cq, ct;
  logic [CH_W-1:0]  r_next, g_next, b_next, s_next, v_next;
  logic [HUE_W-1:0] h_next;
  always_comb begin
    fin = side[DIV_STEPS];
    case (fin.base)
      BASE_GREEN: ofs = OFS_GREEN;
      BASE_BLUE:  ofs = OFS_BLUE;
      default:    ofs = OFS_RED;
    endcase
    hsum = HUE_W'(quo[DIV_STEPS][1]) + ofs;
    if (hsum >= HUE_TURN) hsum = hsum - HUE_TURN;
    // divide by 130560: drop 9 bits, then divide by 255
    tm   = tnum[DIV_STEPS][NUM_W-1:9];
    tsum = tm + 17'd1 + (tm >> 8);
    cp = quo[DIV_STEPS][0][CH_W-1:0];
    cq = quo[DIV_STEPS][1][CH_W-1:0];
    ct = tsum[15:8];
    r_next = '0;
    g_next = '0;
    b_next = '0;
    h_next = '0;
    s_next = '0;
    v_next = '0;
    if (fin.mode == REQ_RGB2HSV) begin
      v_next = fin.val;
      if (!fin.gray) begin
        h_next = hsum;
        s_next = cp;
      end
    end else begin
      unique case (fin.sext)
        3'd0:    begin r_next = fin.val; g_next = ct;      b_next = cp;      end
        3'd1:    begin r_next = cq;      g_next = fin.val; b_next = cp;      end
        3'd2:    begin r_next = cp;      g_next = fin.val; b_next = ct;      end
        3'd3:    begin r_next = cp;      g_next = cq;      b_next = fin.val; end
        3'd4:    begin r_next = ct;      g_next = cp;      b_next = fin.val; end
        default: begin r_next = fin.val; g_next = cp;      b_next = cq;      end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld_div[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red        <= r_next;
      out_green      <= g_next;
      out_blue       <= b_next;
      out_hue        <= h_next;
      out_saturation <= s_next;
      out_value      <= v_next;
      out_alpha      <= fin.alpha;
    end
  end

`include "rgb_hsv_color_convert_assert.svh"

  `RHC_ASSERT(a_hue_range, out_valid |-> out_hue < HUE_TURN, "hue out of range")
  `RHC_ASSERT(a_mode_excl,
    out_valid && (out_red != '0 || out_green != '0 || out_blue != '0)
      |-> out_hue == '0 && out_saturation == '0 && out_value == '0,
    "both result groups set")
  `RHC_ASSERT(a_sat_val, out_valid && out_saturation != '0 |-> out_value != '0,
    "saturation without value")
  `RHC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !vld_front,
    "pipeline not empty after reset")

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rhc_pkg::*;

  typedef struct {
    logic        mode;
    logic [7:0]  r, g, b;
    logic [10:0] h;
    logic [7:0]  s, v, a;
  } pixel_t;

  typedef struct {
    logic [7:0]  r, g, b;
    logic [10:0] h;
    logic [7:0]  s, v, a;
  } color_t;

  typedef struct {
    pixel_t px;
    bit     typed;
    color_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [7:0]  red = '0, green = '0, blue = '0;
  logic [10:0] hue = '0;
  logic [7:0]  saturation = '0, value = '0, alpha = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red, out_green, out_blue;
  logic [10:0] out_hue;
  logic [7:0]  out_saturation, out_value, out_alpha;

  color_t pending_colors[$];
  int     errors = 0;
  bit     hold_out = 1'b0;
  bit     sent_all = 1'b0;

  rgb_hsv_color_convert u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] rdiv(input logic [31:0] num, input logic [31:0] den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic color_t convert_pixel(input pixel_t px);
    color_t c;
    int mx, mn, delta, diff, base, hu;
    logic [31:0] sx, f, p, q, t, h;
    c = '{default: '0};
    c.a = px.a;
    if (px.mode == REQ_RGB2HSV) begin
      mx = px.r; mn = px.r;
      if (px.g > mx) mx = px.g;
      if (px.b > mx) mx = px.b;
      if (px.g < mn) mn = px.g;
      if (px.b < mn) mn = px.b;
      c.v = 8'(mx);
      delta = mx - mn;
      if (delta != 0) begin
        c.s = 8'(rdiv(delta * 255, mx));
        if (px.r == mx) begin
          diff = int'(px.g) - int'(px.b); base = 6;
        end else if (px.g == mx) begin
          diff = int'(px.b) - int'(px.r); base = 2;
        end else begin
          diff = int'(px.r) - int'(px.g); base = 4;
        end
        hu = rdiv(256 * diff + base * 256 * delta, delta);
        while (hu >= 1536) hu -= 1536;
        c.h = 11'(hu);
      end
    end else if (px.s == 0) begin
      c.r = px.v; c.g = px.v; c.b = px.v;
    end else begin
      h = (px.h >= HUE_TURN) ? 0 : px.h;
      sx = h >> 8;
      f = h & 255;
      p = rdiv(px.v * (255 - px.s), 255);
      q = rdiv(px.v * (65280 - px.s * f), 65280);
      t = rdiv(px.v * (65280 - px.s * (256 - f)), 65280);
      case (sx)
        0: begin c.r = px.v; c.g = 8'(t); c.b = 8'(p); end
        1: begin c.r = 8'(q); c.g = px.v; c.b = 8'(p); end
        2: begin c.r = 8'(p); c.g = px.v; c.b = 8'(t); end
        3: begin c.r = 8'(p); c.g = 8'(q); c.b = px.v; end
        4: begin c.r = 8'(t); c.g = 8'(p); c.b = px.v; end
        default: begin c.r = px.v; c.g = 8'(p); c.b = 8'(q); end
      endcase
    end
    return c;
  endfunction

  function automatic pixel_t rgb_px(input logic [7:0] r, g, b, a);
    pixel_t px;
    px = '{mode: REQ_RGB2HSV, r: r, g: g, b: b, h: 11'($urandom), s: 8'($urandom),
           v: 8'($urandom), a: a};
    return px;
  endfunction

  function automatic pixel_t hsv_px(input logic [10:0] h, input logic [7:0] s, v, a);
    pixel_t px;
    px = '{mode: REQ_HSV2RGB, r: 8'($urandom), g: 8'($urandom), b: 8'($urandom),
           h: h, s: s, v: v, a: a};
    return px;
  endfunction

  function automatic color_t hsv_res(input logic [10:0] h, input logic [7:0] s, v, a);
    color_t c;
    c = '{r: '0, g: '0, b: '0, h: h, s: s, v: v, a: a};
    return c;
  endfunction

  function automatic color_t rgb_res(input logic [7:0] r, g, b, a);
    color_t c;
    c = '{r: r, g: g, b: b, h: '0, s: '0, v: '0, a: a};
    return c;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px = '{mode: 1'($urandom), r: 8'($urandom), g: 8'($urandom), b: 8'($urandom),
           h: 11'($urandom_range(1535)), s: 8'($urandom), v: 8'($urandom),
           a: 8'($urandom)};
    case ($urandom_range(9))
      0: px.h = 11'($urandom_range(2047, 1536));
      1: px.s = '0;
      2: begin px.g = px.r; px.b = px.r; end
      3: px.h = 11'($urandom_range(5) * 256 + ($urandom_range(1) ? 255 : 0));
      default: ;
    endcase
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px);
    in_valid   <= 1'b1;
    req_type   <= px.mode;
    red        <= px.r;
    green      <= px.g;
    blue       <= px.b;
    hue        <= px.h;
    saturation <= px.s;
    value      <= px.v;
    alpha      <= px.a;
    do @(posedge clk); while (!in_ready);
    pending_colors.push_back(convert_pixel(px));
  endtask

  task automatic idle_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    color_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected word");
        errors++;
      end else begin
        e = pending_colors.pop_front();
        check_field("out_red", int'(e.r), int'(out_red));
        check_field("out_green", int'(e.g), int'(out_green));
        check_field("out_blue", int'(e.b), int'(out_blue));
        check_field("out_hue", int'(e.h), int'(out_hue));
        check_field("out_saturation", int'(e.s), int'(out_saturation));
        check_field("out_value", int'(e.v), int'(out_value));
        check_field("out_alpha", int'(e.a), int'(out_alpha));
      end
    end
  end

  initial begin
    int cnt;
    int hold_cnt;
    bit hold_seen;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cnt++;
      if (hold_out && !hold_seen) begin
        hold_seen = 1'b1;
        hold_cnt = 120;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (cnt % 300 < 60) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(3) != 0);
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    int   n;
    rows.push_back('{rgb_px(0, 0, 0, 0), 1'b1, hsv_res(0, 0, 0, 0)});
    rows.push_back('{rgb_px(255, 255, 255, 255), 1'b1, hsv_res(0, 0, 255, 255)});
    rows.push_back('{rgb_px(255, 0, 0, 8'h5a), 1'b1, hsv_res(0, 255, 255, 8'h5a)});
    rows.push_back('{rgb_px(0, 255, 0, 8'ha5), 1'b1, hsv_res(512, 255, 255, 8'ha5)});
    rows.push_back('{rgb_px(0, 0, 255, 1), 1'b1, hsv_res(1024, 255, 255, 1)});
    rows.push_back('{rgb_px(255, 255, 0, 2), 1'b1, hsv_res(256, 255, 255, 2)});
    rows.push_back('{rgb_px(255, 0, 255, 3), 1'b1, hsv_res(1280, 255, 255, 3)});
    rows.push_back('{rgb_px(255, 0, 1, 4), 1'b0, '{default: '0}});
    rows.push_back('{rgb_px(128, 128, 128, 5), 1'b1, hsv_res(0, 0, 128, 5)});
    rows.push_back('{hsv_px(0, 0, 200, 6), 1'b1, rgb_res(200, 200, 200, 6)});
    rows.push_back('{hsv_px(0, 255, 255, 7), 1'b1, rgb_res(255, 0, 0, 7)});
    rows.push_back('{hsv_px(512, 255, 255, 8), 1'b1, rgb_res(0, 255, 0, 8)});
    rows.push_back('{hsv_px(1024, 255, 255, 9), 1'b1, rgb_res(0, 0, 255, 9)});
    rows.push_back('{hsv_px(2047, 255, 255, 10), 1'b1, rgb_res(255, 0, 0, 10)});
    rows.push_back('{hsv_px(1536, 100, 0, 11), 1'b1, rgb_res(0, 0, 0, 11)});
    rows.push_back('{hsv_px(1535, 255, 255, 12), 1'b0, '{default: '0}});
    rows.push_back('{hsv_px(255, 255, 255, 13), 1'b0, '{default: '0}});
    rows.push_back('{hsv_px(768, 1, 255, 14), 1'b0, '{default: '0}});
    rows.push_back('{hsv_px(1280, 128, 77, 15), 1'b0, '{default: '0}});
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      rw = rows[i];
      send_pixel(rw.px);
      if (rw.typed) pending_colors[$] = rw.res;
    end
    hold_out = 1'b1;
    repeat (40) send_pixel(random_pixel());
    idle_sender(1);
    while (pending_colors.size() != 0) @(posedge clk);
    while (n < 1200) begin
      repeat ($urandom_range(30, 1)) begin
        send_pixel(random_pixel());
        n++;
      end
      if ($urandom_range(3) == 0) idle_sender($urandom_range(8, 1));
      if (n % 400 < 30 && n > 30) begin
        idle_sender(1);
        while (pending_colors.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    sent_all = 1'b1;
  end

  initial begin
    wait (sent_all);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/rhc_pkg.sv
design/rgb_hsv_color_convert.sv
bench/testbench.sv
